### src/ecam_pkg.sv
// shared types, codes and constants of the euler camera block
package ecam_pkg;

  // event codes
  localparam logic [1:0] OP_LOOK = 2'd0;
  localparam logic [1:0] OP_MOVE = 2'd1;
  localparam logic [1:0] OP_SET  = 2'd2;

  // register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] REG_WORLD_UP_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WORLD_UP_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_WORLD_UP_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MOVE_SPEED = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LOOK_SENS  = 3'd4;

  // angle constants in Q9.16 degrees, plus the cordic gain and the Q14 unit
  localparam logic [33:0]        FULL_TURN    = 34'd23592960;
  localparam logic signed [34:0] HALF_TURN_W  = 35'sd11796480;
  localparam logic signed [34:0] WRAP_OFFSET  = 35'sd3019898880;
  localparam logic signed [25:0] HALF_TURN_Z  = 26'sd11796480;
  localparam logic signed [24:0] QUARTER_TURN = 25'sd5898240;
  localparam logic signed [24:0] PITCH_LIMIT  = 25'sd5832704;
  localparam logic signed [32:0] CORDIC_K     = 33'sd652032874;
  localparam logic signed [15:0] ONE_Q14      = 16'sd16384;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic               clamp_pitch;
    logic               key_forward;
    logic               key_back;
    logic               key_left;
    logic               key_right;
    logic [15:0]        delta_time;
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] front_x;
    logic signed [15:0] front_y;
    logic signed [15:0] front_z;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic signed [15:0] right_z;
    logic signed [15:0] up_x;
    logic signed [15:0] up_y;
    logic signed [15:0] up_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } out_item_t;

  typedef enum logic [4:0] {
    CMD_IDLE, CMD_LOAD, CMD_ANGLE, CMD_WRAP, CMD_ANG_FIN,
    CMD_CORD_INIT, CMD_CORD_STEP, CMD_CORD_FIN, CMD_FRONT, CMD_CROSS,
    CMD_SQ, CMD_SQRT_INIT, CMD_SQRT, CMD_DIV_INIT, CMD_DIV, CMD_DIV_FIN,
    CMD_VEL, CMD_STEP, CMD_SETPOS, CMD_OUT
  } cmd_e;

  typedef enum logic [1:0] {
    V_FRONT, V_RIGHT, V_UP
  } vsel_e;

  typedef struct packed {
    cmd_e       op;
    logic [1:0] idx;
    logic [4:0] cnt;
    logic       sel;
    vsel_e      tgt;
  } cmd_t;

  // arctangent of 2^-i in Q9.16 degrees
  function automatic logic signed [25:0] atan_q16(input logic [3:0] i);
    logic signed [25:0] r;
    case (i)
      4'd0:  r = 26'sd2949120;
      4'd1:  r = 26'sd1740967;
      4'd2:  r = 26'sd919879;
      4'd3:  r = 26'sd466945;
      4'd4:  r = 26'sd234379;
      4'd5:  r = 26'sd117304;
      4'd6:  r = 26'sd58666;
      4'd7:  r = 26'sd29335;
      4'd8:  r = 26'sd14668;
      4'd9:  r = 26'sd7334;
      4'd10: r = 26'sd3667;
      4'd11: r = 26'sd1833;
      4'd12: r = 26'sd917;
      4'd13: r = 26'sd458;
      4'd14: r = 26'sd229;
      default: r = 26'sd115;
    endcase
    return r;
  endfunction

endpackage

### src/ecam_ctrl.sv
// sequencer of the euler camera: steps the datapath through each event
module ecam_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          opcode_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ecam_pkg::cmd_t      cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_ANGLE, S_WRAP, S_ANG_FIN, S_CORD_INIT, S_CORD_STEP, S_CORD_FIN,
    S_FRONT, S_CROSS, S_SQ, S_SQRT_INIT, S_SQRT, S_DIV_INIT, S_DIV, S_DIV_FIN,
    S_VEL, S_STEP, S_SETPOS, S_FINISH
  } state_e;

  state_e          state_q;
  logic [4:0]      cnt_q;
  logic [1:0]      idx_q;
  logic            sel_q;
  ecam_pkg::vsel_e tgt_q;
  logic            out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // result valid: cleared on accept, set when a finished item is handed over
  always_comb begin
    out_valid_d = out_valid_q & ~out_ready_i;
    if ((state_q == S_FINISH) && (!out_valid_q || out_ready_i)) out_valid_d = 1'b1;
  end

  // state, counters and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      sel_q       <= 1'b0;
      tgt_q       <= ecam_pkg::V_FRONT;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (opcode_i)
              ecam_pkg::OP_LOOK: state_q <= S_ANGLE;
              ecam_pkg::OP_MOVE: state_q <= S_VEL;
              ecam_pkg::OP_SET:  state_q <= S_SETPOS;
              default:           state_q <= S_FINISH;
            endcase
          end
        end
        S_ANGLE: begin
          cnt_q   <= 5'd8;
          state_q <= S_WRAP;
        end
        S_WRAP: begin
          if (cnt_q == 5'd0) state_q <= S_ANG_FIN;
          else cnt_q <= cnt_q - 5'd1;
        end
        S_ANG_FIN: begin
          sel_q   <= 1'b0;
          state_q <= S_CORD_INIT;
        end
        S_CORD_INIT: begin
          cnt_q   <= 5'd0;
          state_q <= S_CORD_STEP;
        end
        S_CORD_STEP: begin
          if (cnt_q == 5'd15) state_q <= S_CORD_FIN;
          else cnt_q <= cnt_q + 5'd1;
        end
        S_CORD_FIN: begin
          if (!sel_q) begin
            sel_q   <= 1'b1;
            state_q <= S_CORD_INIT;
          end else begin
            state_q <= S_FRONT;
          end
        end
        S_FRONT: begin
          tgt_q   <= ecam_pkg::V_FRONT;
          idx_q   <= 2'd0;
          state_q <= S_SQ;
        end
        S_CROSS: begin
          if (idx_q == 2'd2) begin
            idx_q   <= 2'd0;
            state_q <= S_SQ;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        S_SQ: begin
          if (idx_q == 2'd2) state_q <= S_SQRT_INIT;
          else idx_q <= idx_q + 2'd1;
        end
        S_SQRT_INIT: begin
          cnt_q   <= 5'd31;
          state_q <= S_SQRT;
        end
        S_SQRT: begin
          if (cnt_q == 5'd0) begin
            idx_q   <= 2'd0;
            state_q <= S_DIV_INIT;
          end else begin
            cnt_q <= cnt_q - 5'd1;
          end
        end
        S_DIV_INIT: begin
          cnt_q   <= 5'd14;
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (cnt_q == 5'd0) state_q <= S_DIV_FIN;
          else cnt_q <= cnt_q - 5'd1;
        end
        S_DIV_FIN: begin
          if (idx_q == 2'd2) begin
            idx_q <= 2'd0;
            case (tgt_q)
              ecam_pkg::V_FRONT: begin
                tgt_q   <= ecam_pkg::V_RIGHT;
                state_q <= S_CROSS;
              end
              ecam_pkg::V_RIGHT: begin
                tgt_q   <= ecam_pkg::V_UP;
                state_q <= S_CROSS;
              end
              default: state_q <= S_FINISH;
            endcase
          end else begin
            idx_q   <= idx_q + 2'd1;
            state_q <= S_DIV_INIT;
          end
        end
        S_VEL: begin
          cnt_q   <= 5'd0;
          idx_q   <= 2'd0;
          state_q <= S_STEP;
        end
        S_STEP: begin
          if (idx_q == 2'd2) begin
            idx_q <= 2'd0;
            if (cnt_q == 5'd3) state_q <= S_FINISH;
            else cnt_q <= cnt_q + 5'd1;
          end else begin
            idx_q <= idx_q + 2'd1;
          end
        end
        S_SETPOS: state_q <= S_FINISH;
        S_FINISH: begin
          if (!out_valid_q || out_ready_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd_o     = '0;
    cmd_o.op  = ecam_pkg::CMD_IDLE;
    cmd_o.idx = idx_q;
    cmd_o.cnt = cnt_q;
    cmd_o.sel = sel_q;
    cmd_o.tgt = tgt_q;
    unique case (state_q)
      S_IDLE:      if (in_valid_i) cmd_o.op = ecam_pkg::CMD_LOAD;
      S_ANGLE:     cmd_o.op = ecam_pkg::CMD_ANGLE;
      S_WRAP:      cmd_o.op = ecam_pkg::CMD_WRAP;
      S_ANG_FIN:   cmd_o.op = ecam_pkg::CMD_ANG_FIN;
      S_CORD_INIT: cmd_o.op = ecam_pkg::CMD_CORD_INIT;
      S_CORD_STEP: cmd_o.op = ecam_pkg::CMD_CORD_STEP;
      S_CORD_FIN:  cmd_o.op = ecam_pkg::CMD_CORD_FIN;
      S_FRONT:     cmd_o.op = ecam_pkg::CMD_FRONT;
      S_CROSS:     cmd_o.op = ecam_pkg::CMD_CROSS;
      S_SQ:        cmd_o.op = ecam_pkg::CMD_SQ;
      S_SQRT_INIT: cmd_o.op = ecam_pkg::CMD_SQRT_INIT;
      S_SQRT:      cmd_o.op = ecam_pkg::CMD_SQRT;
      S_DIV_INIT:  cmd_o.op = ecam_pkg::CMD_DIV_INIT;
      S_DIV:       cmd_o.op = ecam_pkg::CMD_DIV;
      S_DIV_FIN:   cmd_o.op = ecam_pkg::CMD_DIV_FIN;
      S_VEL:       cmd_o.op = ecam_pkg::CMD_VEL;
      S_STEP:      cmd_o.op = ecam_pkg::CMD_STEP;
      S_SETPOS:    cmd_o.op = ecam_pkg::CMD_SETPOS;
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) cmd_o.op = ecam_pkg::CMD_OUT;
      end
      default:     cmd_o.op = ecam_pkg::CMD_IDLE;
    endcase
  end

endmodule

### src/ecam_dp.sv
// datapath of the euler camera: angles, cordic, normalizer and position
module ecam_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  ecam_pkg::cmd_t                    cmd_i,
  input  ecam_pkg::in_item_t                in_data_i,
  input  logic                              cfg_we_i,
  input  logic [ecam_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [15:0]                       cfg_wdata_i,
  output ecam_pkg::out_item_t               out_data_o
);

  // registers and camera state
  logic signed [15:0] wu_q [3];
  logic [15:0]        speed_q, sens_q;
  logic signed [24:0] yaw_q, pitch_q;
  logic signed [15:0] front_q [3];
  logic signed [15:0] right_q [3];
  logic signed [15:0] up_q [3];
  logic signed [31:0] pos_q [3];

  // working registers
  ecam_pkg::in_item_t  in_q;
  ecam_pkg::out_item_t out_q;
  logic [33:0]         wy_q, wp_q;
  logic signed [32:0]  cx_q, cy_q;
  logic signed [25:0]  cz_q;
  logic                cneg_q;
  logic signed [15:0]  syaw_q, cyaw_q, spit_q, cpit_q;
  logic signed [31:0]  vec_q [3];
  logic [63:0]         len2_q, sn_q, sr_q;
  logic [46:0]         num_q;
  logic [14:0]         quo_q;
  logic [31:0]         vel_q;

  // rounded and clamped cordic output in Q14
  function automatic logic signed [15:0] sat_q14(input logic signed [33:0] v);
    logic signed [33:0] t;
    t = (v + 34'sd32768) >>> 16;
    if (t > 34'sd16384) return ecam_pkg::ONE_Q14;
    if (t < -34'sd16384) return -ecam_pkg::ONE_Q14;
    return t[15:0];
  endfunction

  // angle accumulate with offset that keeps the sum positive
  logic signed [32:0] prod_yaw, prod_pit;
  logic signed [34:0] sum_yaw, sum_pit, fin_yaw, fin_pit;
  logic [33:0]        wstep;
  assign prod_yaw = in_q.mouse_dx * $signed({1'b0, sens_q});
  assign prod_pit = in_q.mouse_dy * $signed({1'b0, sens_q});
  assign sum_yaw  = 35'(yaw_q) + 35'(prod_yaw) + ecam_pkg::HALF_TURN_W
                    + ecam_pkg::WRAP_OFFSET;
  assign sum_pit  = 35'(pitch_q) + 35'(prod_pit) + ecam_pkg::HALF_TURN_W
                    + ecam_pkg::WRAP_OFFSET;
  assign wstep    = ecam_pkg::FULL_TURN << cmd_i.cnt[3:0];
  assign fin_yaw  = $signed({1'b0, wy_q}) - ecam_pkg::HALF_TURN_W;
  assign fin_pit  = $signed({1'b0, wp_q}) - ecam_pkg::HALF_TURN_W;

  logic signed [24:0] pit_wr, pit_cl;
  always_comb begin
    pit_wr = fin_pit[24:0];
    pit_cl = pit_wr;
    if (in_q.clamp_pitch) begin
      if (pit_wr > ecam_pkg::PITCH_LIMIT) pit_cl = ecam_pkg::PITCH_LIMIT;
      else if (pit_wr < -ecam_pkg::PITCH_LIMIT) pit_cl = -ecam_pkg::PITCH_LIMIT;
    end
  end

  // cordic range reduction and micro-rotation
  logic signed [24:0] cang;
  logic signed [32:0] cxs, cys;
  logic signed [33:0] cxf, cyf;
  assign cang = cmd_i.sel ? pitch_q : yaw_q;
  assign cxs  = cx_q >>> cmd_i.cnt[3:0];
  assign cys  = cy_q >>> cmd_i.cnt[3:0];
  assign cxf  = cneg_q ? -34'(cx_q) : 34'(cx_q);
  assign cyf  = cneg_q ? -34'(cy_q) : 34'(cy_q);

  // cross product operands, one component per cycle
  logic signed [15:0] ca [3];
  logic signed [15:0] cb [3];
  logic signed [15:0] ap, aq, bp, bq;
  logic signed [31:0] xp1, xp2;
  logic signed [32:0] xdiff;
  always_comb begin
    if (cmd_i.tgt == ecam_pkg::V_UP) begin
      ca[0] = right_q[0]; ca[1] = right_q[1]; ca[2] = right_q[2];
      cb[0] = front_q[0]; cb[1] = front_q[1]; cb[2] = front_q[2];
    end else begin
      ca[0] = front_q[0]; ca[1] = front_q[1]; ca[2] = front_q[2];
      cb[0] = wu_q[0];    cb[1] = wu_q[1];    cb[2] = wu_q[2];
    end
    case (cmd_i.idx)
      2'd0: begin ap = ca[1]; aq = ca[2]; bp = cb[1]; bq = cb[2]; end
      2'd1: begin ap = ca[2]; aq = ca[0]; bp = cb[2]; bq = cb[0]; end
      default: begin ap = ca[0]; aq = ca[1]; bp = cb[0]; bq = cb[1]; end
    endcase
  end
  assign xp1   = ap * bq;
  assign xp2   = aq * bp;
  assign xdiff = 33'(xp1) - 33'(xp2);

  // magnitude of the selected component
  logic signed [31:0] vsel;
  logic [31:0]        vmag;
  logic [63:0]        vsq;
  assign vsel = vec_q[cmd_i.idx];
  assign vmag = vsel[31] ? 32'(-vsel) : 32'(vsel);
  assign vsq  = vmag * vmag;

  // square root step
  logic [63:0] srb;
  assign srb = sr_q + (64'd1 << {cmd_i.cnt, 1'b0});

  // division step and result
  logic [46:0]        dshift;
  logic [14:0]        qcl;
  logic signed [15:0] qval;
  assign dshift = {15'd0, sr_q[31:0]} << cmd_i.cnt[3:0];
  assign qcl    = (quo_q > 15'd16384) ? 15'd16384 : quo_q;
  assign qval   = vsel[31] ? -$signed({1'b0, qcl}) : $signed({1'b0, qcl});

  // front vector products
  logic signed [31:0] f0, f2;
  assign f0 = cyaw_q * cpit_q;
  assign f2 = syaw_q * cpit_q;

  // move step along a basis vector component
  logic [3:0]         keys;
  logic               key_on, key_neg;
  logic signed [15:0] dir;
  logic signed [48:0] mprod, mrnd;
  logic signed [33:0] mstep, newp;
  logic signed [31:0] psat;
  assign keys    = {in_q.key_right, in_q.key_left, in_q.key_back, in_q.key_forward};
  assign key_on  = keys[cmd_i.cnt[1:0]];
  assign key_neg = (cmd_i.cnt[1:0] == 2'd1) || (cmd_i.cnt[1:0] == 2'd2);
  assign dir     = cmd_i.cnt[1] ? right_q[cmd_i.idx] : front_q[cmd_i.idx];
  assign mprod   = $signed({1'b0, vel_q}) * dir;
  assign mrnd    = (mprod + 49'sd2097152) >>> 22;
  assign mstep   = mrnd[33:0];
  assign newp    = key_neg ? 34'(pos_q[cmd_i.idx]) - mstep
                           : 34'(pos_q[cmd_i.idx]) + mstep;
  always_comb begin
    if (newp > 34'sd2147483647) psat = 32'sh7fffffff;
    else if (newp < -34'sd2147483648) psat = 32'sh80000000;
    else psat = newp[31:0];
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wu_q[0] <= 16'sd0;
      wu_q[1] <= 16'sd16384;
      wu_q[2] <= 16'sd0;
      speed_q <= 16'd640;
      sens_q  <= 16'd6554;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ecam_pkg::REG_WORLD_UP_X: wu_q[0] <= cfg_wdata_i;
        ecam_pkg::REG_WORLD_UP_Y: wu_q[1] <= cfg_wdata_i;
        ecam_pkg::REG_WORLD_UP_Z: wu_q[2] <= cfg_wdata_i;
        ecam_pkg::REG_MOVE_SPEED: speed_q <= cfg_wdata_i;
        ecam_pkg::REG_LOOK_SENS:  sens_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // camera state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yaw_q      <= -ecam_pkg::QUARTER_TURN;
      pitch_q    <= 25'sd0;
      front_q[0] <= 16'sd0;
      front_q[1] <= 16'sd0;
      front_q[2] <= -ecam_pkg::ONE_Q14;
      right_q[0] <= ecam_pkg::ONE_Q14;
      right_q[1] <= 16'sd0;
      right_q[2] <= 16'sd0;
      up_q[0]    <= 16'sd0;
      up_q[1]    <= ecam_pkg::ONE_Q14;
      up_q[2]    <= 16'sd0;
      pos_q[0]   <= 32'sd0;
      pos_q[1]   <= 32'sd0;
      pos_q[2]   <= 32'sd0;
    end else begin
      case (cmd_i.op)
        ecam_pkg::CMD_ANG_FIN: begin
          yaw_q   <= fin_yaw[24:0];
          pitch_q <= pit_cl;
        end
        ecam_pkg::CMD_DIV_FIN: begin
          if (len2_q != 64'd0) begin
            case (cmd_i.tgt)
              ecam_pkg::V_FRONT: front_q[cmd_i.idx] <= qval;
              ecam_pkg::V_RIGHT: right_q[cmd_i.idx] <= qval;
              default:           up_q[cmd_i.idx]    <= qval;
            endcase
          end
        end
        ecam_pkg::CMD_STEP: begin
          if (key_on) pos_q[cmd_i.idx] <= psat;
        end
        ecam_pkg::CMD_SETPOS: begin
          pos_q[0] <= in_q.new_pos_x;
          pos_q[1] <= in_q.new_pos_y;
          pos_q[2] <= in_q.new_pos_z;
        end
        default: ;
      endcase
    end
  end

  // working registers of the shared units
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      ecam_pkg::CMD_LOAD: in_q <= in_data_i;
      ecam_pkg::CMD_ANGLE: begin
        wy_q <= sum_yaw[33:0];
        wp_q <= sum_pit[33:0];
      end
      ecam_pkg::CMD_WRAP: begin
        if (wy_q >= wstep) wy_q <= wy_q - wstep;
        if (wp_q >= wstep) wp_q <= wp_q - wstep;
      end
      ecam_pkg::CMD_CORD_INIT: begin
        cx_q <= ecam_pkg::CORDIC_K;
        cy_q <= 33'sd0;
        if (cang > ecam_pkg::QUARTER_TURN) begin
          cz_q   <= 26'(cang) - ecam_pkg::HALF_TURN_Z;
          cneg_q <= 1'b1;
        end else if (cang < -ecam_pkg::QUARTER_TURN) begin
          cz_q   <= 26'(cang) + ecam_pkg::HALF_TURN_Z;
          cneg_q <= 1'b1;
        end else begin
          cz_q   <= 26'(cang);
          cneg_q <= 1'b0;
        end
      end
      ecam_pkg::CMD_CORD_STEP: begin
        if (!cz_q[25]) begin
          cx_q <= cx_q - cys;
          cy_q <= cy_q + cxs;
          cz_q <= cz_q - ecam_pkg::atan_q16(cmd_i.cnt[3:0]);
        end else begin
          cx_q <= cx_q + cys;
          cy_q <= cy_q - cxs;
          cz_q <= cz_q + ecam_pkg::atan_q16(cmd_i.cnt[3:0]);
        end
      end
      ecam_pkg::CMD_CORD_FIN: begin
        if (cmd_i.sel) begin
          cpit_q <= sat_q14(cxf);
          spit_q <= sat_q14(cyf);
        end else begin
          cyaw_q <= sat_q14(cxf);
          syaw_q <= sat_q14(cyf);
        end
      end
      ecam_pkg::CMD_FRONT: begin
        vec_q[0] <= f0;
        vec_q[1] <= {{2{spit_q[15]}}, spit_q, 14'd0};
        vec_q[2] <= f2;
      end
      ecam_pkg::CMD_CROSS: vec_q[cmd_i.idx] <= xdiff[31:0];
      ecam_pkg::CMD_SQ: begin
        if (cmd_i.idx == 2'd0) len2_q <= vsq;
        else len2_q <= len2_q + vsq;
      end
      ecam_pkg::CMD_SQRT_INIT: begin
        sn_q <= len2_q;
        sr_q <= 64'd0;
      end
      ecam_pkg::CMD_SQRT: begin
        if (sn_q >= srb) begin
          sn_q <= sn_q - srb;
          sr_q <= (sr_q >> 1) + (64'd1 << {cmd_i.cnt, 1'b0});
        end else begin
          sr_q <= sr_q >> 1;
        end
      end
      ecam_pkg::CMD_DIV_INIT: begin
        num_q <= {1'b0, vmag, 14'd0} + {16'd0, sr_q[31:1]};
        quo_q <= '0;
      end
      ecam_pkg::CMD_DIV: begin
        if (num_q >= dshift) begin
          num_q <= num_q - dshift;
          quo_q[cmd_i.cnt[3:0]] <= 1'b1;
        end
      end
      ecam_pkg::CMD_VEL: vel_q <= speed_q * in_q.delta_time;
      ecam_pkg::CMD_OUT: begin
        out_q.front_x <= front_q[0];
        out_q.front_y <= front_q[1];
        out_q.front_z <= front_q[2];
        out_q.right_x <= right_q[0];
        out_q.right_y <= right_q[1];
        out_q.right_z <= right_q[2];
        out_q.up_x    <= up_q[0];
        out_q.up_y    <= up_q[1];
        out_q.up_z    <= up_q[2];
        out_q.pos_x   <= pos_q[0];
        out_q.pos_y   <= pos_q[1];
        out_q.pos_z   <= pos_q[2];
      end
      default: ;
    endcase
  end

  assign out_data_o = out_q;

endmodule

### src/euler_camera_look_and_move.sv
// top level of the first-person euler camera
// One item at a time. A look item runs one accumulate step, nine wrap
// steps and a store for the angles, two CORDIC runs, one step for the
// front products, then three normalizations (the last two begin with the
// cross product), each built from a bit-serial square root and a
// bit-serial divider run for each component, and ends with a hand-over.
// A move item runs one velocity multiply, then one step per key and
// component; a set-position item stores the new position, and an unused
// opcode goes straight to the hand-over. The result sits in an output
// register, so the next item is taken while the previous result waits;
// the hand-over stalls only while that result is still unaccepted.
// Register writes are taken at any time and must only be made while the
// block is idle.
module euler_camera_look_and_move (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ecam_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output ecam_pkg::out_item_t               out_data_o,
  input  logic                              cfg_we_i,
  input  logic [ecam_pkg::CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [15:0]                       cfg_wdata_i
);

  ecam_pkg::cmd_t cmd;

  // sequencer
  ecam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (in_data_i.opcode),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // datapath
  ecam_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_data_o  (out_data_o)
  );

endmodule

### tb/sv/ecam_checker.sv
// checker for the euler camera: camera state prediction and result comparison
module ecam_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  ecam_pkg::in_item_t              in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  ecam_pkg::out_item_t             out_data_i,
  input  logic                            cfg_we_i,
  input  logic [ecam_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [15:0]                     cfg_wdata_i,
  output int                              fail_count_o,
  output int                              pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint DEG_Q16   = 65536;
  localparam longint TURN_Q16  = 360 * DEG_Q16;
  localparam longint HALF_Q16  = 180 * DEG_Q16;
  localparam longint QUART_Q16 = 90 * DEG_Q16;
  localparam longint LIMIT_Q16 = 89 * DEG_Q16;
  localparam longint UNIT_Q14  = 16384;
  localparam longint GAIN_Q30  = 652032874;
  localparam longint POS_HI    = 64'sd2147483647;
  localparam longint POS_LO    = -64'sd2147483648;

  // camera state copy
  longint up_world[3];
  longint speed_q8, sens_q16;
  longint yaw_q16, pitch_q16;
  longint front_v[3], right_v[3], up_v[3], pos_v[3];
  ecam_pkg::out_item_t camera_q[$];

  longint atan_tab[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

  function automatic longint sra(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wrap_deg(longint a);
    longint r;
    r = (a + HALF_Q16) % TURN_Q16;
    if (r < 0) r += TURN_Q16;
    return r - HALF_Q16;
  endfunction

  function automatic longint root_floor(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // cordic sine and cosine in q14
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, nx;
    bit flip;
    x = GAIN_Q30; y = 0; z = ang; flip = 0;
    if (z > QUART_Q16) begin
      z -= HALF_Q16; flip = 1;
    end else if (z < -QUART_Q16) begin
      z += HALF_Q16; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - sra(y, i); y = y + sra(x, i); z -= atan_tab[i];
      end else begin
        nx = x + sra(y, i); y = y - sra(x, i); z += atan_tab[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip(sra(x + 32768, 16), -UNIT_Q14, UNIT_Q14);
    s = clip(sra(y + 32768, 16), -UNIT_Q14, UNIT_Q14);
  endtask

  // unit length in q14, zero vector leaves target alone
  task automatic to_unit(input longint v[3], inout longint dst[3]);
    longint sq, len, m, q;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      m = v[i] < 0 ? -v[i] : v[i];
      sq += m * m;
    end
    if (sq != 0) begin
      len = root_floor(sq);
      for (int i = 0; i < 3; i++) begin
        m = v[i] < 0 ? -v[i] : v[i];
        q = (m * UNIT_Q14 + len / 2) / len;
        if (q > UNIT_Q14) q = UNIT_Q14;
        dst[i] = v[i] < 0 ? -q : q;
      end
    end
  endtask

  task automatic cross3(input longint a[3], input longint b[3], output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endtask

  task automatic step_along(input longint dir[3], input longint vel, input longint sgn);
    longint d;
    for (int i = 0; i < 3; i++) begin
      d = sra(vel * dir[i] + (64'sd1 << 21), 22);
      pos_v[i] = clip(pos_v[i] + sgn * d, POS_LO, POS_HI);
    end
  endtask

  task automatic camera_update(input ecam_pkg::in_item_t it);
    longint sy, cy, sp, cp, vel;
    longint f[3], c[3];
    ecam_pkg::out_item_t r;
    case (it.opcode)
      ecam_pkg::OP_LOOK: begin
        yaw_q16 = wrap_deg(yaw_q16 + longint'(it.mouse_dx) * sens_q16);
        pitch_q16 = wrap_deg(pitch_q16 + longint'(it.mouse_dy) * sens_q16);
        if (it.clamp_pitch) pitch_q16 = clip(pitch_q16, -LIMIT_Q16, LIMIT_Q16);
        sin_cos(yaw_q16, sy, cy);
        sin_cos(pitch_q16, sp, cp);
        f[0] = cy * cp; f[1] = sp * UNIT_Q14; f[2] = sy * cp;
        to_unit(f, front_v);
        cross3(front_v, up_world, c);
        to_unit(c, right_v);
        cross3(right_v, front_v, c);
        to_unit(c, up_v);
      end
      ecam_pkg::OP_MOVE: begin
        vel = speed_q8 * longint'(it.delta_time);
        if (it.key_forward) step_along(front_v, vel, 1);
        if (it.key_back)    step_along(front_v, vel, -1);
        if (it.key_left)    step_along(right_v, vel, -1);
        if (it.key_right)   step_along(right_v, vel, 1);
      end
      ecam_pkg::OP_SET: begin
        pos_v[0] = it.new_pos_x; pos_v[1] = it.new_pos_y; pos_v[2] = it.new_pos_z;
      end
      default: ;
    endcase
    r.front_x = 16'(front_v[0]); r.front_y = 16'(front_v[1]); r.front_z = 16'(front_v[2]);
    r.right_x = 16'(right_v[0]); r.right_y = 16'(right_v[1]); r.right_z = 16'(right_v[2]);
    r.up_x = 16'(up_v[0]); r.up_y = 16'(up_v[1]); r.up_z = 16'(up_v[2]);
    r.pos_x = 32'(pos_v[0]); r.pos_y = 32'(pos_v[1]); r.pos_z = 32'(pos_v[2]);
    camera_q.push_back(r);
  endtask

  task automatic cmp(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s: expected %0d, got %0d", name, e, a);
      fail_count_o++;
    end
  endtask

  assign pending_o = camera_q.size();

  // watch the channels
  always @(posedge clk_i or negedge rst_ni) begin
    ecam_pkg::out_item_t e, a;
    if (!rst_ni) begin
      up_world = '{0, 16384, 0};
      speed_q8 = 640; sens_q16 = 6554;
      yaw_q16 = -QUART_Q16; pitch_q16 = 0;
      front_v = '{0, 0, -16384}; right_v = '{16384, 0, 0};
      up_v = '{0, 16384, 0}; pos_v = '{0, 0, 0};
      camera_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          ecam_pkg::REG_WORLD_UP_X: up_world[0] = longint'($signed(cfg_wdata_i));
          ecam_pkg::REG_WORLD_UP_Y: up_world[1] = longint'($signed(cfg_wdata_i));
          ecam_pkg::REG_WORLD_UP_Z: up_world[2] = longint'($signed(cfg_wdata_i));
          ecam_pkg::REG_MOVE_SPEED: speed_q8 = cfg_wdata_i;
          ecam_pkg::REG_LOOK_SENS:  sens_q16 = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        a = out_data_i;
        if (camera_q.size() == 0) begin
          $error("result item with none expected");
          fail_count_o++;
        end else begin
          e = camera_q.pop_front();
          cmp("front_x", e.front_x, a.front_x);
          cmp("front_y", e.front_y, a.front_y);
          cmp("front_z", e.front_z, a.front_z);
          cmp("right_x", e.right_x, a.right_x);
          cmp("right_y", e.right_y, a.right_y);
          cmp("right_z", e.right_z, a.right_z);
          cmp("up_x", e.up_x, a.up_x);
          cmp("up_y", e.up_y, a.up_y);
          cmp("up_z", e.up_z, a.up_z);
          cmp("pos_x", e.pos_x, a.pos_x);
          cmp("pos_y", e.pos_y, a.pos_y);
          cmp("pos_z", e.pos_z, a.pos_z);
        end
      end
      if (in_valid_i && in_ready_i) camera_update(in_data_i);
    end
  end
endmodule

### tb/sv/testbench.sv
// testbench top: camera stimulus, register phases and verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // opcode with no event behind it and a register index past the list
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam logic [ecam_pkg::CFG_ADDR_W-1:0] REG_NONE = '1;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, in_ready_o, out_valid_o, out_ready_i = 0;
  ecam_pkg::in_item_t in_data_i = '0;
  ecam_pkg::out_item_t out_data_o;
  logic cfg_we_i = 0;
  logic [ecam_pkg::CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [15:0] cfg_wdata_i = '0;
  int fail_count, pending;
  bit stim_done = 0;

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  euler_camera_look_and_move u_top (.*);

  ecam_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_data_i(out_data_o),
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side stalls, with a quiet stretch now and then
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (!stim_done && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1;
        repeat ($urandom_range(20, 200)) @(posedge clk_i);
      end
      g = gap_len();
      out_ready_i <= (g == 0);
      if (g != 0) begin
        repeat (g - 1) @(posedge clk_i);
        @(posedge clk_i);
        out_ready_i <= 1;
      end
    end
  end

  // valid stays high from one item to the next when there is no gap
  task automatic send_item(input ecam_pkg::in_item_t it);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // stop sending and wait until every expected result has come
  task automatic wait_idle();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_idle();
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [ecam_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we_i <= 1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  function automatic ecam_pkg::in_item_t look_item(input logic signed [15:0] dx,
                                                   input logic signed [15:0] dy,
                                                   input logic clamp);
    ecam_pkg::in_item_t it;
    it = ecam_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.opcode = ecam_pkg::OP_LOOK; it.mouse_dx = dx; it.mouse_dy = dy;
    it.clamp_pitch = clamp;
    return it;
  endfunction

  function automatic ecam_pkg::in_item_t move_item(input logic [3:0] keys,
                                                   input logic [15:0] dt);
    ecam_pkg::in_item_t it;
    it = ecam_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.opcode = ecam_pkg::OP_MOVE;
    {it.key_forward, it.key_back, it.key_left, it.key_right} = keys;
    it.delta_time = dt;
    return it;
  endfunction

  function automatic ecam_pkg::in_item_t set_item(input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic signed [31:0] z);
    ecam_pkg::in_item_t it;
    it = ecam_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    it.opcode = ecam_pkg::OP_SET; it.new_pos_x = x; it.new_pos_y = y; it.new_pos_z = z;
    return it;
  endfunction

  function automatic logic signed [15:0] small_or_any();
    return ($urandom_range(0, 9) < 8) ? 16'($signed($urandom_range(0, 400)) - 200)
                                      : 16'($urandom);
  endfunction

  function automatic ecam_pkg::in_item_t rand_item();
    ecam_pkg::in_item_t it;
    int p;
    p = $urandom_range(0, 99);
    it = ecam_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    if (p < 40) it = look_item(small_or_any(), small_or_any(), 1'($urandom_range(0, 1)));
    else if (p < 80) it = move_item(4'($urandom), 16'($urandom));
    else if (p < 93) begin
      it = set_item($urandom, $urandom, $urandom);
      if ($urandom_range(0, 1)) it.new_pos_x = 32'h7fff_0000;
    end else it.opcode = OP_NONE;
    return it;
  endfunction

  // stimulus
  initial begin
    logic [15:0] up_sets[4][3] = '{'{16'd0, 16'd16384, 16'd0},
                                   '{16'hc000, 16'd0, 16'd0},
                                   '{16'd0, 16'd0, 16'd0},
                                   '{16'd5000, 16'hf000, 16'd9000}};
    logic [15:0] speeds[4] = '{16'd640, 16'hffff, 16'd0, 16'd3000};
    logic [15:0] senss[4] = '{16'd6554, 16'd0, 16'hffff, 16'd40000};
    ecam_pkg::in_item_t it;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes and special cases at reset settings
    send_item(move_item(4'b1111, 16'hffff));
    send_item(look_item(16'sd0, 16'sd0, 1'b0));
    send_item(look_item(16'sh7fff, 16'sh7fff, 1'b0));
    send_item(look_item(-16'sd32768, -16'sd32768, 1'b1));
    send_item(look_item(16'sd0, 16'sd2000, 1'b1));
    send_item(look_item(16'sd0, -16'sd4000, 1'b1));
    send_item(look_item(16'sd900, 16'sd0, 1'b0));
    send_item(set_item(32'h7fffffff, 32'h80000000, 32'h0));
    send_item(move_item(4'b1000, 16'hffff));
    send_item(move_item(4'b0100, 16'hffff));
    send_item(move_item(4'b0010, 16'hffff));
    send_item(move_item(4'b0001, 16'hffff));
    send_item(set_item(32'h80000000, 32'h7fffffff, 32'hffffffff));
    send_item(move_item(4'b1111, 16'd0));
    it = rand_item(); it.opcode = OP_NONE; send_item(it);
    // two unclamped pitch steps of about 90 degrees, the second wrapping past 180
    send_item(look_item(16'sd0, 16'sd900, 1'b0));
    send_item(look_item(16'sd0, 16'sd900, 1'b0));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 3; k++)
        write_reg(ecam_pkg::CFG_ADDR_W'(k), up_sets[ph][k]);
      write_reg(ecam_pkg::REG_MOVE_SPEED, speeds[ph]);
      write_reg(ecam_pkg::REG_LOOK_SENS, senss[ph]);
      write_reg(REG_NONE, 16'hffff);
      cfg_we_i <= 0;
      for (int n = 0; n < 285; n++) begin
        send_item(rand_item());
        if (n == 140) wait_idle();
      end
      drain();
    end
    stim_done = 1;
    if (fail_count == 0) begin
      $display("euler_camera_look_and_move: match");
    end else begin
      $display("euler_camera_look_and_move: mismatch");
    end
    $finish;
  end

  // timeout
  initial begin
    #20ms;
    $display("euler_camera_look_and_move: mismatch");
    $finish;
  end
endmodule
